[rtl/bresenham_line_stepper_core_macros.svh]
// Assertion macros shared by the line stepper checker.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef BRESENHAM_LINE_STEPPER_CORE_MACROS_SVH
`define BRESENHAM_LINE_STEPPER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define BLS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line stepper check failed (same cycle)");

// Next-cycle implication, disabled while in reset
`define BLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line stepper check failed (next cycle)");

`endif

[rtl/bls_pkg.sv]
// Shared constants for the Bresenham line stepper.
// No dependencies; used by the core and its checker.
`timescale 1ns / 1ps

package bls_pkg;

  // Request action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // Colour index width
  localparam int unsigned PAINT_BITS = 8;

endpackage

[rtl/bresenham_line_stepper_core.sv]
// Bresenham line stepper core: one grid cell per accepted request.
// Throughput: one request per cycle while the skid register is empty; a
// two-entry output stage (result register plus skid register) keeps input
// ready while one result waits.
// Reset (synchronous, rst_n low): no line in progress, all line state zero,
// output stage empty.
`timescale 1ns / 1ps

module bresenham_line_stepper_core #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic [COORD_BITS-1:0]           in_start_col,
  input  logic [COORD_BITS-1:0]           in_start_row,
  input  logic [COORD_BITS-1:0]           in_end_col,
  input  logic [COORD_BITS-1:0]           in_end_row,
  input  logic [bls_pkg::PAINT_BITS-1:0]  in_paint,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [COORD_BITS-1:0]           out_cell_col,
  output logic [COORD_BITS-1:0]           out_cell_row,
  output logic [bls_pkg::PAINT_BITS-1:0]  out_cell_paint,
  output logic                            out_last,
  output logic                            out_stale
);

  localparam int unsigned C = COORD_BITS;
  localparam int unsigned E = COORD_BITS + 3;  // error accumulator width

  typedef struct packed {
    logic [C-1:0]                   col;
    logic [C-1:0]                   row;
    logic [bls_pkg::PAINT_BITS-1:0] paint;
    logic                           last;
    logic                           stale;
  } cell_t;

  // Line state
  logic [C-1:0]                   cur_col_r, cur_col_nxt;
  logic [C-1:0]                   cur_row_r, cur_row_nxt;
  logic [C-1:0]                   goal_col_r, goal_col_nxt;
  logic [C-1:0]                   goal_row_r, goal_row_nxt;
  logic [1:0]                     col_step_r, col_step_nxt;
  logic [1:0]                     row_step_r, row_step_nxt;
  logic [C:0]                     twice_dcol_r, twice_dcol_nxt;
  logic [C:0]                     twice_drow_r, twice_drow_nxt;
  logic signed [E-1:0]            err_acc_r, err_acc_nxt;
  logic                           col_major_r, col_major_nxt;
  logic                           active_r, active_nxt;
  logic [bls_pkg::PAINT_BITS-1:0] held_paint_r, held_paint_nxt;

  // Output stage
  cell_t out_r, out_nxt;
  cell_t skid_r, skid_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic  skid_valid_r, skid_valid_nxt;

  cell_t res;
  logic  accept;

  // Setup terms for a start request
  logic signed [C:0] dc, dr;
  logic [C-1:0]      adc, adr;
  logic              st_major;

  // Step terms
  logic        err_pos, err_zero, minor_move;
  logic [C:0]  tw_major, tw_minor;
  logic [1:0]  major_step;
  logic [E-1:0] sub_term;

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;

  // Start setup: signed deltas, magnitudes and major axis
  always_comb begin
    dc       = $signed({1'b0, in_end_col}) - $signed({1'b0, in_start_col});
    dr       = $signed({1'b0, in_end_row}) - $signed({1'b0, in_start_row});
    adc      = dc[C] ? C'(-dc) : dc[C-1:0];
    adr      = dr[C] ? C'(-dr) : dr[C-1:0];
    st_major = (adc >= adr);
  end

  // Step decision on the registered error
  always_comb begin
    err_pos    = !err_acc_r[E-1] && (err_acc_r != '0);
    err_zero   = (err_acc_r == '0);
    major_step = col_major_r ? col_step_r : row_step_r;
    tw_major   = col_major_r ? twice_dcol_r : twice_drow_r;
    tw_minor   = col_major_r ? twice_drow_r : twice_dcol_r;
    // tie at zero moves the minor axis only for a positive major step
    minor_move = err_pos || (err_zero && (major_step == 2'b01));
    sub_term   = minor_move ? {2'b00, tw_major} : '0;
  end

  // Next line state and result
  always_comb begin
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    goal_col_nxt   = goal_col_r;
    goal_row_nxt   = goal_row_r;
    col_step_nxt   = col_step_r;
    row_step_nxt   = row_step_r;
    twice_dcol_nxt = twice_dcol_r;
    twice_drow_nxt = twice_drow_r;
    err_acc_nxt    = err_acc_r;
    col_major_nxt  = col_major_r;
    active_nxt     = active_r;
    held_paint_nxt = held_paint_r;
    res.stale      = 1'b0;

    if (in_action == bls_pkg::ACT_START) begin
      cur_col_nxt    = in_start_col;
      cur_row_nxt    = in_start_row;
      goal_col_nxt   = in_end_col;
      goal_row_nxt   = in_end_row;
      held_paint_nxt = in_paint;
      col_step_nxt   = (dc == '0) ? 2'b00 : (dc[C] ? 2'b11 : 2'b01);
      row_step_nxt   = (dr == '0) ? 2'b00 : (dr[C] ? 2'b11 : 2'b01);
      twice_dcol_nxt = {adc, 1'b0};
      twice_drow_nxt = {adr, 1'b0};
      col_major_nxt  = st_major;
      // initial error: doubled minor delta less the major delta
      err_acc_nxt    = st_major ? ($signed({2'b00, adr, 1'b0}) - $signed({3'b000, adc}))
                                : ($signed({2'b00, adc, 1'b0}) - $signed({3'b000, adr}));
      active_nxt     = !((in_start_col == in_end_col) && (in_start_row == in_end_row));
    end else if (!active_r) begin
      res.stale = 1'b1;
    end else begin
      err_acc_nxt = err_acc_r - $signed(sub_term) + $signed({2'b00, tw_minor});
      if (col_major_r) begin
        cur_col_nxt = cur_col_r + {{(C-1){col_step_r[1]}}, col_step_r[0]};
        if (minor_move) begin
          cur_row_nxt = cur_row_r + {{(C-1){row_step_r[1]}}, row_step_r[0]};
        end
        active_nxt = (cur_col_nxt != goal_col_r);
      end else begin
        cur_row_nxt = cur_row_r + {{(C-1){row_step_r[1]}}, row_step_r[0]};
        if (minor_move) begin
          cur_col_nxt = cur_col_r + {{(C-1){col_step_r[1]}}, col_step_r[0]};
        end
        active_nxt = (cur_row_nxt != goal_row_r);
      end
    end

    res.col   = cur_col_nxt;
    res.row   = cur_row_nxt;
    res.paint = held_paint_nxt;
    res.last  = !res.stale && !active_nxt;
  end

  // Line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      goal_col_r   <= '0;
      goal_row_r   <= '0;
      col_step_r   <= '0;
      row_step_r   <= '0;
      twice_dcol_r <= '0;
      twice_drow_r <= '0;
      err_acc_r    <= '0;
      col_major_r  <= 1'b0;
      active_r     <= 1'b0;
      held_paint_r <= '0;
    end else if (accept) begin
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      goal_col_r   <= goal_col_nxt;
      goal_row_r   <= goal_row_nxt;
      col_step_r   <= col_step_nxt;
      row_step_r   <= row_step_nxt;
      twice_dcol_r <= twice_dcol_nxt;
      twice_drow_r <= twice_drow_nxt;
      err_acc_r    <= err_acc_nxt;
      col_major_r  <= col_major_nxt;
      active_r     <= active_nxt;
      held_paint_r <= held_paint_nxt;
    end
  end

  // Output stage: skid entry is always older than a new result
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_nxt       = res;
        skid_valid_nxt = accept;
      end else begin
        out_nxt       = res;
        out_valid_nxt = accept;
      end
    end else if (accept) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cell_col   = out_r.col;
  assign out_cell_row   = out_r.row;
  assign out_cell_paint = out_r.paint;
  assign out_last       = out_r.last;
  assign out_stale      = out_r.stale;

endmodule

[rtl/bls_checker.sv]
// Port-level checker for the Bresenham line stepper core, with its bind.
// Depends on bls_pkg and bresenham_line_stepper_core_macros.svh.
`timescale 1ns / 1ps
`include "bresenham_line_stepper_core_macros.svh"

module bls_checker #(
  parameter int unsigned COORD_BITS = 12
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_action,
  input logic [COORD_BITS-1:0]           in_start_col,
  input logic [COORD_BITS-1:0]           in_start_row,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [COORD_BITS-1:0]           out_cell_col,
  input logic [COORD_BITS-1:0]           out_cell_row,
  input logic [bls_pkg::PAINT_BITS-1:0]  out_cell_paint,
  input logic                            out_last,
  input logic                            out_stale
);

  // a request only stalls when both output entries hold results
  `BLS_ASSERT_IMPL(a_stall_needs_result, !in_ready, out_valid)

  // a stale repeat is never the end of a line
  `BLS_ASSERT_IMPL(a_last_not_stale, out_valid, !(out_last && out_stale))

  // a start into an empty output shows its first endpoint next cycle
  `BLS_ASSERT_NEXT(a_start_first_cell,
    in_valid && in_ready && (in_action == bls_pkg::ACT_START) && !out_valid,
    out_valid && !out_stale && (out_cell_col == $past(in_start_col)) &&
    (out_cell_row == $past(in_start_row)))

  // a stalled result holds its cell
  `BLS_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
    out_valid && $stable(out_cell_col) && $stable(out_cell_row) &&
    $stable(out_cell_paint))

endmodule

bind bresenham_line_stepper_core bls_checker #(.COORD_BITS(COORD_BITS)) u_bls_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_action      (in_action),
  .in_start_col   (in_start_col),
  .in_start_row   (in_start_row),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_cell_col   (out_cell_col),
  .out_cell_row   (out_cell_row),
  .out_cell_paint (out_cell_paint),
  .out_last       (out_last),
  .out_stale      (out_stale)
);
